>>> src/libc_pkg.sv
// shared types and constants for the lazy invert bitset counter
// no dependencies; imported by every module of the block
package libc_pkg;

  localparam int unsigned CNT_W = 11;
  localparam int unsigned IDX_W = 10;
  localparam logic [CNT_W-1:0] SIZE_RESET = 11'd1024;

  typedef enum logic [1:0] {
    CMD_SET   = 2'd0,
    CMD_CLR   = 2'd1,
    CMD_FLIP  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t             command;
    logic [IDX_W-1:0] bit_index;
  } in_item_t;

  typedef struct packed {
    logic             all_set;
    logic             any_set;
    logic [CNT_W-1:0] ones_count;
    logic             index_error;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic clear_start;
    logic clear_step;
    logic load_item;
    logic lookup;
    logic apply;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dp_sts_t;

endpackage

>>> src/libc_ctrl.sv
// controller state machine: clearing pass, item accept, lookup and apply
// depends on libc_pkg
module libc_ctrl
  import libc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    cfg_wr,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_LOOKUP = 4'b0100,
    ST_APPLY  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE) && !cfg_wr;

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.clear_start = cfg_wr;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = !cfg_wr;
        if (!cfg_wr && sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.load_item = in_valid && in_ready;
        if (in_valid && in_ready) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = ST_APPLY;
      end
      ST_APPLY: begin
        // hold until the output register can take the result
        cmd.apply = sts.out_free;
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
    if (cfg_wr) begin
      state_nxt = ST_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/libc_dpath.sv
// datapath: bit store, invert flag, ones counter, size register, result register
// depends on libc_pkg
module libc_dpath
  import libc_pkg::*;
#(
  parameter int unsigned SIZE = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dp_cmd_t          cmd,
  output dp_sts_t          sts,
  input  in_item_t         in_data,
  input  logic             cfg_wr,
  input  logic [CNT_W-1:0] cfg_size,
  output logic [CNT_W-1:0] size_r,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  localparam int unsigned AW = (SIZE > 1) ? $clog2(SIZE) : 1;
  localparam int unsigned SIZE_CLAMP = (SIZE > 2047) ? 2047 : SIZE;
  localparam logic [CNT_W-1:0] SizeMax = CNT_W'(SIZE_CLAMP);
  localparam logic [AW-1:0] LastAddr = AW'(SIZE - 1);

  logic             mem [SIZE];
  logic             rd_bit_r;
  logic [AW-1:0]    clr_addr_r;
  in_item_t         item_r;
  logic             inv_r, inv_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  out_item_t        out_r, out_nxt;

  logic [CNT_W-1:0] n;
  logic [31:0]      idx_wide;
  logic [AW-1:0]    item_addr;
  logic             bit_cmd, in_range, want, change, mem_we, mem_wbit;
  logic [AW-1:0]    mem_waddr;

  // active size clamped to one..SIZE, and to at most 2047
  always_comb begin
    priority if (size_r == '0) begin
      n = CNT_W'(1);
    end else if (size_r > SizeMax) begin
      n = SizeMax;
    end else begin
      n = size_r;
    end
  end

  assign idx_wide  = 32'(item_r.bit_index);
  assign item_addr = idx_wide[AW-1:0];
  assign bit_cmd   = (item_r.command == CMD_SET) || (item_r.command == CMD_CLR);
  assign in_range  = {1'b0, item_r.bit_index} < n;
  assign want      = (item_r.command == CMD_SET);
  assign change    = bit_cmd && in_range && ((rd_bit_r ^ inv_r) != want);

  always_comb begin
    count_nxt = count_r;
    inv_nxt   = inv_r;
    if (item_r.command == CMD_FLIP) begin
      inv_nxt   = !inv_r;
      count_nxt = (count_r <= n) ? (n - count_r) : '0;
    end else if (change) begin
      if (want) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (count_r != '0) begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
    out_nxt.all_set     = (count_nxt == n);
    out_nxt.any_set     = (count_nxt != '0);
    out_nxt.ones_count  = count_nxt;
    out_nxt.index_error = bit_cmd && !in_range;
  end

  assign mem_we    = cmd.clear_step || (cmd.apply && change);
  assign mem_waddr = cmd.clear_step ? clr_addr_r : item_addr;
  assign mem_wbit  = cmd.clear_step ? 1'b0 : (want ^ inv_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wbit;
    end
    if (cmd.lookup) begin
      rd_bit_r <= mem[item_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    if (cmd.apply) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= SIZE_RESET;
      inv_r       <= 1'b0;
      count_r     <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        size_r <= cfg_size;
      end
      if (cmd.clear_start) begin
        inv_r      <= 1'b0;
        count_r    <= '0;
        clr_addr_r <= '0;
      end else begin
        if (cmd.clear_step) begin
          clr_addr_r <= clr_addr_r + AW'(1);
        end
        if (cmd.apply) begin
          inv_r   <= inv_nxt;
          count_r <= count_nxt;
        end
      end
      if (cmd.apply) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.clear_last = (clr_addr_r == LastAddr);
  assign sts.out_free   = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_data       = out_r;

endmodule

>>> src/lazy_invert_bitset_counter_top.sv
// Bit vector of SIZE one-bit cells with a lazy whole-vector invert flag and a
// running ones count. Commands are set, clear, flip all and query; every item
// returns one result with all_set, any_set, the count and an index error flag
// (a set or clear at or beyond the active size changes nothing). The active
// size is the size_in_use register, decoded at every address, clamped to
// 1..SIZE and at most 2047. An item passes accept, store read, then update
// and write, as the single-port bit store's registered read sits between
// accept and update; the update waits while the output register is full.
// The next item is accepted while a result waits in the output register.
// After reset and after every write of size_in_use it clears all SIZE cells
// (one cell per cycle) with in_ready low; register accesses are taken as always.
// depends on libc_pkg, libc_ctrl and libc_dpath
module lazy_invert_bitset_counter_top
  import libc_pkg::*;
#(
  parameter int unsigned SIZE = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // item input
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic             cfg_wr;
  logic [CNT_W-1:0] size_r;
  logic             addr_ok;

  // only one register, so every address decodes to size_in_use
  assign addr_ok    = (cfg_paddr == cfg_paddr);
  assign cfg_pready = 1'b1;
  // write completes in the access phase
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && addr_ok;
  assign cfg_prdata = 32'(size_r);

  libc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cfg_wr   (cfg_wr),
    .sts      (sts),
    .cmd      (cmd)
  );

  libc_dpath #(
    .SIZE (SIZE)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_wr    (cfg_wr),
    .cfg_size  (cfg_pwdata[CNT_W-1:0]),
    .size_r    (size_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> src/libc_checker.sv
// port-level checker for the lazy invert bitset counter, bound to the top level
// depends on libc_pkg and lazy_invert_bitset_counter_top
module libc_checker
  import libc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data,
  input logic      cfg_psel,
  input logic      cfg_penable,
  input logic      cfg_pwrite
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // any_set agrees with the count
  a_any_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.any_set == (out_data.ones_count != '0)))
    else $error("any_set disagrees with ones_count");

  // active size is at least one, so all set implies a nonzero count
  a_all_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.all_set |-> out_data.ones_count != '0)
    else $error("all_set with zero count");

  // a size write starts the clearing pass
  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite |=> !in_ready)
    else $error("input taken right after size write");

  // no result right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind lazy_invert_bitset_counter_top libc_checker u_libc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_data    (out_data),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite)
);
